// ===== rtl/cht_pkg.sv =====
// Package for the cookie header tokenizer.
// Holds byte class codes, result codes, character constants and the queue entry type.
// No dependencies.
package cht_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_ZERO      = 8'h00;

    localparam logic [3:0] CL_OTHER  = 4'd0;
    localparam logic [3:0] CL_SPACE  = 4'd1;
    localparam logic [3:0] CL_EQUAL  = 4'd2;
    localparam logic [3:0] CL_SEMI   = 4'd3;
    localparam logic [3:0] CL_COMMA  = 4'd4;
    localparam logic [3:0] CL_DOLLAR = 4'd5;
    localparam logic [3:0] CL_BSLASH = 4'd6;
    localparam logic [3:0] CL_QUOTE  = 4'd7;
    localparam logic [3:0] CL_ZERO   = 4'd8;

    localparam logic [1:0] RL_SKIP    = 2'd0;
    localparam logic [1:0] RL_VERSION = 2'd1;
    localparam logic [1:0] RL_NAME    = 2'd2;
    localparam logic [1:0] RL_VALUE   = 2'd3;

    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_COOKIE   = 3'd1;
    localparam logic [2:0] ST_ATTR     = 3'd2;
    localparam logic [2:0] ST_NO_EQ    = 3'd3;
    localparam logic [2:0] ST_ESCAPE   = 3'd4;
    localparam logic [2:0] ST_QUOTE    = 3'd5;
    localparam logic [2:0] ST_ATTR_1ST = 3'd6;
    localparam logic [2:0] ST_ATTR_NS  = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic [3:0] cls;
    } t_entry;

endpackage

// ===== rtl/cht_front.sv =====
// Front end of the cookie header tokenizer: classifies each incoming byte.
// Depends on cht_pkg.
module cht_front (
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_header,
    output cht_pkg::t_entry o_entry
);

    logic [3:0] cls;

    always_comb begin
        cls = cht_pkg::CL_OTHER;
        if (i_data_byte == cht_pkg::CH_ZERO) begin
            cls = cht_pkg::CL_ZERO;
        end else if (i_data_byte == cht_pkg::CH_SPACE ||
                     (i_data_byte >= cht_pkg::CH_TAB && i_data_byte <= cht_pkg::CH_CR)) begin
            cls = cht_pkg::CL_SPACE;
        end else if (i_data_byte == cht_pkg::CH_EQUAL) begin
            cls = cht_pkg::CL_EQUAL;
        end else if (i_data_byte == cht_pkg::CH_SEMICOLON) begin
            cls = cht_pkg::CL_SEMI;
        end else if (i_data_byte == cht_pkg::CH_COMMA) begin
            cls = cht_pkg::CL_COMMA;
        end else if (i_data_byte == cht_pkg::CH_DOLLAR) begin
            cls = cht_pkg::CL_DOLLAR;
        end else if (i_data_byte == cht_pkg::CH_BACKSLASH) begin
            cls = cht_pkg::CL_BSLASH;
        end else if (i_data_byte == cht_pkg::CH_QUOTE) begin
            cls = cht_pkg::CL_QUOTE;
        end
    end

    assign o_entry.data_byte = i_data_byte;
    assign o_entry.last      = i_end_of_header;
    assign o_entry.cls       = cls;

endmodule

// ===== rtl/cht_queue.sv =====
// Short queue between the classifier and the parser of the tokenizer.
// Depends on cht_pkg.
module cht_queue #(
    parameter int DEPTH = cht_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cht_pkg::t_entry i_entry,
    input  logic            i_pop,
    output cht_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    cht_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_entry = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

// ===== rtl/cht_back.sv =====
// Back end of the cookie header tokenizer: parse state machine and result register.
// Depends on cht_pkg.
module cht_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cht_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte_out,
    output logic [1:0]      o_role,
    output logic            o_pair_kind,
    output logic [2:0]      o_pair_status,
    output logic            o_header_is_rfc,
    output logic            o_last_out
);

    localparam logic [2:0] PH_LEAD    = 3'd0;
    localparam logic [2:0] PH_VERSION = 3'd1;
    localparam logic [2:0] PH_GAP     = 3'd2;
    localparam logic [2:0] PH_NAME    = 3'd3;
    localparam logic [2:0] PH_EQ      = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;
    localparam logic [2:0] PH_ESC     = 3'd6;
    localparam logic [2:0] PH_HALT    = 3'd7;

    localparam logic [1:0] RL_SKIP    = cht_pkg::RL_SKIP;
    localparam logic [1:0] RL_VERSION = cht_pkg::RL_VERSION;
    localparam logic [1:0] RL_NAME    = cht_pkg::RL_NAME;
    localparam logic [1:0] RL_VALUE   = cht_pkg::RL_VALUE;

    localparam logic [2:0] ST_NONE     = cht_pkg::ST_NONE;
    localparam logic [2:0] ST_COOKIE   = cht_pkg::ST_COOKIE;
    localparam logic [2:0] ST_ATTR     = cht_pkg::ST_ATTR;
    localparam logic [2:0] ST_NO_EQ    = cht_pkg::ST_NO_EQ;
    localparam logic [2:0] ST_ESCAPE   = cht_pkg::ST_ESCAPE;
    localparam logic [2:0] ST_QUOTE    = cht_pkg::ST_QUOTE;
    localparam logic [2:0] ST_ATTR_1ST = cht_pkg::ST_ATTR_1ST;
    localparam logic [2:0] ST_ATTR_NS  = cht_pkg::ST_ATTR_NS;

    logic [2:0] r_phase;
    logic       r_quote;
    logic       r_rfc;
    logic       r_seen;
    logic       r_attr;
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic [1:0] r_role;
    logic       r_kind;
    logic [2:0] r_status;
    logic       r_rfc_out;
    logic       r_last;

    logic [2:0] n_phase;
    logic       n_quote;
    logic       n_rfc;
    logic       n_seen;
    logic       n_attr;
    logic [2:0] eff_phase;
    logic [1:0] role;
    logic [2:0] status;
    logic       kind;
    logic       rfc_out;
    logic       ends;
    logic [3:0] cls;
    logic       pop;

    assign cls  = i_entry.cls;
    assign ends = (cls == cht_pkg::CL_ZERO) || i_entry.last;
    assign pop  = !i_empty && (!r_out_valid || i_ready);

    always_comb begin
        n_phase   = r_phase;
        n_quote   = r_quote;
        n_rfc     = r_rfc;
        n_seen    = r_seen;
        n_attr    = r_attr;
        role      = RL_SKIP;
        status    = ST_NONE;
        kind      = 1'b0;
        eff_phase = r_phase;
        if (r_phase == PH_LEAD && cls != cht_pkg::CL_SPACE && cls != cht_pkg::CL_DOLLAR) begin
            eff_phase = PH_GAP;
        end else if (r_phase == PH_EQ && cls != cht_pkg::CL_EQUAL &&
                     cls != cht_pkg::CL_SPACE) begin
            eff_phase = PH_VALUE;
        end
        if (cls != cht_pkg::CL_ZERO) begin
            unique case (eff_phase)
                PH_LEAD: begin
                    if (cls == cht_pkg::CL_DOLLAR) begin
                        n_rfc   = 1'b1;
                        n_phase = PH_VERSION;
                        role    = RL_VERSION;
                    end
                end
                PH_VERSION: begin
                    if (cls == cht_pkg::CL_SPACE) begin
                        n_phase = PH_GAP;
                    end else begin
                        role = RL_VERSION;
                    end
                end
                PH_GAP: begin
                    n_phase = PH_GAP;
                    if (cls == cht_pkg::CL_COMMA) begin
                        n_phase = PH_LEAD;
                        n_quote = 1'b0;
                        n_rfc   = 1'b0;
                        n_seen  = 1'b0;
                        n_attr  = 1'b0;
                    end else if (cls == cht_pkg::CL_DOLLAR) begin
                        kind = 1'b1;
                        if (!r_seen || !r_rfc) begin
                            status  = r_seen ? ST_ATTR_NS : ST_ATTR_1ST;
                            n_phase = PH_HALT;
                        end else begin
                            n_attr  = 1'b1;
                            n_quote = 1'b0;
                            n_phase = PH_NAME;
                            role    = RL_NAME;
                        end
                    end else if (cls != cht_pkg::CL_SEMI && cls != cht_pkg::CL_SPACE) begin
                        n_attr  = 1'b0;
                        n_quote = 1'b0;
                        if (cls == cht_pkg::CL_EQUAL) begin
                            n_phase = PH_EQ;
                        end else begin
                            n_phase = PH_NAME;
                            role    = RL_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    kind = r_attr;
                    if (cls == cht_pkg::CL_EQUAL || cls == cht_pkg::CL_SPACE) begin
                        n_phase = PH_EQ;
                    end else begin
                        role = RL_NAME;
                    end
                end
                PH_EQ: begin
                    kind = r_attr;
                end
                PH_VALUE: begin
                    kind    = r_attr;
                    n_phase = PH_VALUE;
                    if (!r_quote && (cls == cht_pkg::CL_SEMI || cls == cht_pkg::CL_COMMA)) begin
                        status = r_attr ? ST_ATTR : ST_COOKIE;
                        if (!r_attr) begin
                            n_seen = 1'b1;
                        end
                        n_attr = 1'b0;
                        if (cls == cht_pkg::CL_COMMA) begin
                            n_phase = PH_LEAD;
                            n_quote = 1'b0;
                            n_rfc   = 1'b0;
                            n_seen  = 1'b0;
                        end else begin
                            n_phase = PH_GAP;
                        end
                    end else begin
                        role = RL_VALUE;
                        if (cls == cht_pkg::CL_BSLASH) begin
                            n_phase = PH_ESC;
                        end else if (cls == cht_pkg::CL_QUOTE) begin
                            n_quote = !r_quote;
                        end
                    end
                end
                PH_ESC: begin
                    kind    = r_attr;
                    n_phase = PH_VALUE;
                    role    = RL_VALUE;
                end
                PH_HALT: begin
                    role = RL_SKIP;
                end
                default: begin
                    role = RL_SKIP;
                end
            endcase
        end
        rfc_out = n_rfc;
        if (ends && status == ST_NONE) begin
            unique case (n_phase)
                PH_NAME: begin
                    status = ST_NO_EQ;
                    kind   = n_attr;
                end
                PH_EQ: begin
                    status = n_attr ? ST_ATTR : ST_COOKIE;
                    kind   = n_attr;
                end
                PH_VALUE: begin
                    status = n_quote ? ST_QUOTE : (n_attr ? ST_ATTR : ST_COOKIE);
                    kind   = n_attr;
                end
                PH_ESC: begin
                    status = ST_ESCAPE;
                    kind   = n_attr;
                end
                default: begin
                    status = ST_NONE;
                end
            endcase
        end
        if (ends) begin
            n_phase = PH_LEAD;
            n_quote = 1'b0;
            n_rfc   = 1'b0;
            n_seen  = 1'b0;
            n_attr  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_quote     <= 1'b0;
            r_rfc       <= 1'b0;
            r_seen      <= 1'b0;
            r_attr      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase <= n_phase;
                r_quote <= n_quote;
                r_rfc   <= n_rfc;
                r_seen  <= n_seen;
                r_attr  <= n_attr;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_byte    <= i_entry.data_byte;
            r_role    <= role;
            r_kind    <= kind;
            r_status  <= status;
            r_rfc_out <= rfc_out;
            r_last    <= i_entry.last;
        end
    end

    assign o_pop           = pop;
    assign o_valid         = r_out_valid;
    assign o_byte_out      = r_byte;
    assign o_role          = r_role;
    assign o_pair_kind     = r_kind;
    assign o_pair_status   = r_status;
    assign o_header_is_rfc = r_rfc_out;
    assign o_last_out      = r_last;

endmodule

// ===== rtl/cookie_header_tokenizer.sv =====
// Cookie header tokenizer top level: classifier, queue and parser.
// Depends on cht_pkg, cht_front, cht_queue and cht_back.
//
// The block takes one Cookie header byte per clock while the queue has room and
// returns one classified result per byte, in order. A byte is classified on
// transfer and written into a short queue; while the queue holds an entry and
// the result register is free or being read, the parser pops one entry per
// clock into it. Sustained rate is one byte per cycle unless the output stalls.
// The queue depth sets how many bytes can be absorbed while the output stalls.
module cookie_header_tokenizer #(
    parameter int QUEUE_DEPTH = cht_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_header,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte_out,
    output logic [1:0] o_role,
    output logic       o_pair_kind,
    output logic [2:0] o_pair_status,
    output logic       o_header_is_rfc,
    output logic       o_last_out
);

    cht_pkg::t_entry in_entry;
    cht_pkg::t_entry q_entry;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic            push;

    assign o_ready = !q_full;
    assign push    = i_valid && !q_full;

    cht_front u_front (
        .i_data_byte     (i_data_byte),
        .i_end_of_header (i_end_of_header),
        .o_entry         (in_entry)
    );

    cht_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (in_entry),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cht_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry         (q_entry),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_byte_out      (o_byte_out),
        .o_role          (o_role),
        .o_pair_kind     (o_pair_kind),
        .o_pair_status   (o_pair_status),
        .o_header_is_rfc (o_header_is_rfc),
        .o_last_out      (o_last_out)
    );

endmodule

// ===== rtl/cht_checker.sv =====
// Port-level checks for the cookie header tokenizer, bound to the top level.
// Depends on cht_pkg and cookie_header_tokenizer.
module cht_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_byte_out,
    input logic [1:0] o_role,
    input logic       o_pair_kind,
    input logic [2:0] o_pair_status,
    input logic       o_header_is_rfc
);

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result shown right after reset.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_byte_out) && $stable(o_pair_status))
        else $error("Stalled result changed.");

    a_version_is_rfc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_role == cht_pkg::RL_VERSION |-> o_header_is_rfc)
        else $error("Version token byte in a Netscape header.");

    a_status_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pair_status == cht_pkg::ST_ATTR ||
                    o_pair_status == cht_pkg::ST_ATTR_1ST ||
                    o_pair_status == cht_pkg::ST_ATTR_NS) |-> o_pair_kind)
        else $error("Attribute status without attribute kind.");

    a_cookie_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pair_status == cht_pkg::ST_COOKIE |-> !o_pair_kind)
        else $error("Cookie status with attribute kind.");

endmodule

bind cookie_header_tokenizer cht_checker u_cht_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_byte_out      (o_byte_out),
    .o_role          (o_role),
    .o_pair_kind     (o_pair_kind),
    .o_pair_status   (o_pair_status),
    .o_header_is_rfc (o_header_is_rfc)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the cookie header tokenizer.
// Drives header bytes through valid/ready with random idling, predicts every result
// with its own tokenizer model and compares field by field; depends on cht_pkg and the RTL.
module tb_top;

    localparam int RANDOM_BYTES = 1200;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum logic [2:0] {
        PH_LEAD, PH_VERSION, PH_GAP, PH_NAME, PH_EQ, PH_VALUE, PH_ESC, PH_HALT
    } t_phase;

    localparam logic [1:0] ROLE_NONE    = 2'd0;
    localparam logic [1:0] ROLE_VERSION = 2'd1;
    localparam logic [1:0] ROLE_NAME    = 2'd2;
    localparam logic [1:0] ROLE_VALUE   = 2'd3;

    localparam logic [2:0] ST_NONE          = 3'd0;
    localparam logic [2:0] ST_COOKIE_DONE   = 3'd1;
    localparam logic [2:0] ST_ATTR_DONE     = 3'd2;
    localparam logic [2:0] ST_NO_EQUALS     = 3'd3;
    localparam logic [2:0] ST_TRAIL_ESC     = 3'd4;
    localparam logic [2:0] ST_OPEN_QUOTE    = 3'd5;
    localparam logic [2:0] ST_ATTR_FIRST    = 3'd6;
    localparam logic [2:0] ST_ATTR_NETSCAPE = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_hdr_byte;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] role;
        logic       kind;
        logic [2:0] status;
        logic       rfc;
        logic       last;
    } t_token;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_end_of_header = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_byte_out;
    logic [1:0] o_role;
    logic       o_pair_kind;
    logic [2:0] o_pair_status;
    logic       o_header_is_rfc;
    logic       o_last_out;

    t_hdr_byte header_bytes_q[$];
    t_token    expected_tokens_q[$];

    t_phase phase;
    bit     quote_open;
    bit     rfc_mode;
    bit     cookie_seen;
    bit     attr_pair;

    bit calm;
    int gap_left;
    int stall_left;
    int mismatches;
    int cycle_count;

    cookie_header_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_header (i_end_of_header),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_byte_out      (o_byte_out),
        .o_role          (o_role),
        .o_pair_kind     (o_pair_kind),
        .o_pair_status   (o_pair_status),
        .o_header_is_rfc (o_header_is_rfc),
        .o_last_out      (o_last_out)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit is_blank(input logic [7:0] b);
        return b == cht_pkg::CH_SPACE || (b >= cht_pkg::CH_TAB && b <= cht_pkg::CH_CR);
    endfunction

    task automatic clear_header();
        phase       = PH_LEAD;
        quote_open  = 1'b0;
        rfc_mode    = 1'b0;
        cookie_seen = 1'b0;
        attr_pair   = 1'b0;
    endtask

    task automatic tokenize_byte(input t_hdr_byte in, output t_token tok);
        logic [7:0] b;
        logic [1:0] role;
        logic [2:0] status;
        logic       kind;
        bit         ends;
        bit         again;
        b      = in.data;
        role   = ROLE_NONE;
        status = ST_NONE;
        kind   = 1'b0;
        ends   = (b == cht_pkg::CH_ZERO) || in.last;
        again  = (b != cht_pkg::CH_ZERO);
        while (again) begin
            again = 1'b0;
            case (phase)
                PH_LEAD: begin
                    if (b == cht_pkg::CH_DOLLAR) begin
                        rfc_mode = 1'b1;
                        phase    = PH_VERSION;
                        role     = ROLE_VERSION;
                    end else if (!is_blank(b)) begin
                        phase = PH_GAP;
                        again = 1'b1;
                    end
                end
                PH_VERSION: begin
                    if (is_blank(b)) phase = PH_GAP;
                    else role = ROLE_VERSION;
                end
                PH_GAP: begin
                    if (b == cht_pkg::CH_COMMA) begin
                        clear_header();
                    end else if (b == cht_pkg::CH_DOLLAR) begin
                        kind = 1'b1;
                        if (!cookie_seen || !rfc_mode) begin
                            status = cookie_seen ? ST_ATTR_NETSCAPE : ST_ATTR_FIRST;
                            phase  = PH_HALT;
                        end else begin
                            attr_pair  = 1'b1;
                            quote_open = 1'b0;
                            phase      = PH_NAME;
                            role       = ROLE_NAME;
                        end
                    end else if (b != cht_pkg::CH_SEMICOLON && !is_blank(b)) begin
                        attr_pair  = 1'b0;
                        quote_open = 1'b0;
                        if (b == cht_pkg::CH_EQUAL) begin
                            phase = PH_EQ;
                        end else begin
                            phase = PH_NAME;
                            role  = ROLE_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    kind = attr_pair;
                    if (b == cht_pkg::CH_EQUAL || is_blank(b)) phase = PH_EQ;
                    else role = ROLE_NAME;
                end
                PH_EQ: begin
                    if (b == cht_pkg::CH_EQUAL || is_blank(b)) begin
                        kind = attr_pair;
                    end else begin
                        phase = PH_VALUE;
                        again = 1'b1;
                    end
                end
                PH_VALUE: begin
                    kind = attr_pair;
                    if (!quote_open &&
                        (b == cht_pkg::CH_SEMICOLON || b == cht_pkg::CH_COMMA)) begin
                        status = attr_pair ? ST_ATTR_DONE : ST_COOKIE_DONE;
                        if (!attr_pair) cookie_seen = 1'b1;
                        attr_pair = 1'b0;
                        if (b == cht_pkg::CH_COMMA) clear_header();
                        else phase = PH_GAP;
                    end else begin
                        if (b == cht_pkg::CH_BACKSLASH) phase = PH_ESC;
                        else if (b == cht_pkg::CH_QUOTE) quote_open = !quote_open;
                        role = ROLE_VALUE;
                    end
                end
                PH_ESC: begin
                    kind  = attr_pair;
                    phase = PH_VALUE;
                    role  = ROLE_VALUE;
                end
                default: begin
                end
            endcase
        end
        // A header that ends mid-pair reports how far the pair got.
        if (ends && status == ST_NONE) begin
            case (phase)
                PH_NAME: begin
                    status = ST_NO_EQUALS;
                    kind   = attr_pair;
                end
                PH_EQ: begin
                    status = attr_pair ? ST_ATTR_DONE : ST_COOKIE_DONE;
                    kind   = attr_pair;
                end
                PH_VALUE: begin
                    if (quote_open) status = ST_OPEN_QUOTE;
                    else status = attr_pair ? ST_ATTR_DONE : ST_COOKIE_DONE;
                    kind = attr_pair;
                end
                PH_ESC: begin
                    status = ST_TRAIL_ESC;
                    kind   = attr_pair;
                end
                default: begin
                end
            endcase
        end
        tok = '{data: b, role: role, kind: kind, status: status, rfc: rfc_mode,
                last: in.last};
        if (ends) clear_header();
    endtask

    task automatic push_byte(input logic [7:0] b, input bit last);
        t_hdr_byte hb;
        hb = '{data: b, last: last};
        header_bytes_q.push_back(hb);
    endtask

    task automatic push_text(input string s, input bit last);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], last && i == s.len() - 1);
    endtask

    task automatic mark_last();
        t_hdr_byte hb;
        hb = header_bytes_q.pop_back();
        hb.last = 1'b1;
        header_bytes_q.push_back(hb);
    endtask

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return cht_pkg::CH_TAB;
        if (r == 1) return 8'($urandom_range(10, 13));
        return cht_pkg::CH_SPACE;
    endfunction

    function automatic logic [7:0] pick_token_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (is_blank(b)) b = 8'($urandom_range(1, 255));
        return b;
    endfunction

    function automatic logic [7:0] pick_letter();
        return 8'($urandom_range(8'h41, 8'h7A));
    endfunction

    task automatic push_value();
        int r;
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 11);
            if (r == 0) begin
                push_byte(cht_pkg::CH_QUOTE, 1'b0);
            end else if (r == 1) begin
                push_byte(cht_pkg::CH_BACKSLASH, 1'b0);
                push_byte(8'($urandom_range(1, 255)), 1'b0);
            end else if (r == 2) begin
                push_byte(($urandom_range(0, 1) != 0) ? cht_pkg::CH_SEMICOLON :
                          cht_pkg::CH_EQUAL, 1'b0);
            end else begin
                push_byte(pick_letter(), 1'b0);
            end
        end
    endtask

    // Mostly well-formed headers with random content, some raw noise.
    task automatic gen_header();
        int r;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12))
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            return;
        end
        repeat ($urandom_range(0, 2)) push_byte(pick_blank(), 1'b0);
        if ($urandom_range(0, 1) != 0) begin
            push_byte(cht_pkg::CH_DOLLAR, 1'b0);
            repeat ($urandom_range(0, 3)) push_byte(pick_token_byte(), 1'b0);
            push_byte(pick_blank(), 1'b0);
        end
        for (int p = 0; p < $urandom_range(1, 4); p++) begin
            if (p > 0) begin
                push_byte(($urandom_range(0, 7) == 0) ? cht_pkg::CH_COMMA :
                          cht_pkg::CH_SEMICOLON, 1'b0);
                if ($urandom_range(0, 1) != 0) push_byte(pick_blank(), 1'b0);
                if ($urandom_range(0, 2) == 0) push_byte(cht_pkg::CH_DOLLAR, 1'b0);
            end
            repeat ($urandom_range(0, 5)) push_byte(pick_letter(), 1'b0);
            r = $urandom_range(0, 5);
            if (r <= 2) push_byte(cht_pkg::CH_EQUAL, 1'b0);
            else if (r == 3) push_byte(pick_blank(), 1'b0);
            else if (r == 4) begin
                push_byte(pick_blank(), 1'b0);
                push_byte(cht_pkg::CH_EQUAL, 1'b0);
            end
            push_value();
        end
        r = $urandom_range(0, 5);
        if (r <= 2) mark_last();
        else if (r <= 4) push_byte(cht_pkg::CH_ZERO, $urandom_range(0, 1) != 0);
        else push_byte(cht_pkg::CH_COMMA, 1'b0);
    endtask

    function automatic int draw_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_hdr_byte hb;
        t_token    tok;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            clear_header();
        end else begin
            if (i_valid && o_ready) begin
                hb = '{data: i_data_byte, last: i_end_of_header};
                tokenize_byte(hb, tok);
                expected_tokens_q.push_back(tok);
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (header_bytes_q.size() > 0) begin
                    hb = header_bytes_q.pop_front();
                    i_valid         <= 1'b1;
                    i_data_byte     <= hb.data;
                    i_end_of_header <= hb.last;
                    if ($urandom_range(0, 99) == 0) calm = !calm;
                    gap_left = draw_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_token tok;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_tokens_q.size() == 0) begin
                    $error("result transfer with no expected result, byte %0d", o_byte_out);
                    mismatches++;
                end else begin
                    tok = expected_tokens_q.pop_front();
                    check_field("byte_out", tok.data, o_byte_out);
                    check_field("role", tok.role, o_role);
                    check_field("pair_kind", tok.kind, o_pair_kind);
                    check_field("pair_status", tok.status, o_pair_status);
                    check_field("header_is_rfc", tok.rfc, o_header_is_rfc);
                    check_field("last_out", tok.last, o_last_out);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 4) == 0) stall_left = draw_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        // Directed headers: version token, escapes inside quotes, attribute done,
        // comma into a Netscape header, empty name, attribute in Netscape, halt.
        push_text("$1\tA=\"\\;\";$p=v,=x;$", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(cht_pkg::CH_ZERO, 1'b0);
        push_text("$1\n$a", 1'b1);
        push_text("n", 1'b1);
        push_text("k=\\", 1'b1);
        push_text("k=\"v", 1'b1);
        // Space after a name, then skipped blanks and equals, zero flagged as last.
        push_text("a", 1'b0);
        push_byte(8'h0B, 1'b0);
        push_byte(8'h0C, 1'b0);
        push_byte(cht_pkg::CH_EQUAL, 1'b0);
        push_byte(cht_pkg::CH_CR, 1'b0);
        push_text("b", 1'b0);
        push_byte(cht_pkg::CH_ZERO, 1'b1);
        while (header_bytes_q.size() < RANDOM_BYTES + 40) gen_header();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (header_bytes_q.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_tokens_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
